// ===== rtl/utvm_pkg.sv =====
// Package for the ultrasonic tank volume meter.
// Phase codes, timing constants, register indexes, conversion constants and
// the command/status structs shared by the controller and the datapath.
package utvm_pkg;

  // Measurement phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LOW  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT = 3'd3;
  localparam logic [2:0] PH_ECHO = 3'd4;

  // Trigger pulse timing in ticks
  localparam int PULSE_HIGH_US = 15;
  localparam int PULSE_LOW_US  = 2;

  localparam logic [16:0] CNT_MAX = 17'h1FFFF;

  // Configuration register indexes
  localparam logic [2:0] CFG_DIA   = 3'd0;
  localparam logic [2:0] CFG_DEPTH = 3'd1;
  localparam logic [2:0] CFG_CAP   = 3'd2;
  localparam logic [2:0] CFG_TMO   = 3'd3;

  // volume = D^2 * H * CONV / 1e19, H in 1e-5 cm, D in tenths of a cm
  localparam logic [34:0] CONV    = 35'd20748002837;
  localparam logic [63:0] DIVISOR = 64'd10000000000000000000;
  localparam logic [26:0] DEPTH_SCALE = 27'd10000;
  localparam logic [27:0] ECHO_SCALE  = 28'd1715;

  // 1e19 = 5^19 * 2^19; quotient estimate uses floor(2^89 / 1e19)
  localparam logic [89:0] TWO_POW_89 = 90'd1 << 89;
  localparam logic [25:0] RECIP      = 26'(TWO_POW_89 / {26'd0, DIVISOR});
  localparam logic [44:0] FIVE_19    = 45'(DIVISOR >> 19);

  localparam logic [25:0] POS_SAT = 26'd16777215;
  localparam logic [25:0] NEG_SAT = 26'd16777216;

  typedef struct packed {
    logic step;       // item accepted this cycle
    logic vol_start;  // kick the volume unit
    logic load_out;   // move pending result into the output register
  } cmd_t;

  typedef struct packed {
    logic fin_ok;     // offered item ends a measurement with a valid echo
    logic vol_done;   // volume unit has a result
  } sts_t;

endpackage

// ===== rtl/ultrasonic_tank_volume_meter.sv =====
// Ultrasonic tank volume meter, top level. An item that does not end a measurement with
// a good echo has its result held pending, then moved to the output register when free;
// one that does first waits in the volume unit (scaling, three multiply steps, reciprocal
// quotient estimate, two-step product, correction, saturation). Throughput: one item per
// cycle when the output drains; a finishing item stalls input until the volume unit is
// done. Reset (rst_n, sync) loads register defaults, clears phase, counters, volume, flags.
module ultrasonic_tank_volume_meter
  import utvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input items: op (0 start, 1 tick) and sampled echo level
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic               in_echo_level,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_trigger_level,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic               out_timed_out,
  output logic signed [24:0] out_volume_hundredth_gal,
  output logic               out_full_res,
  output logic               out_empty_res,
  // configuration writes, always taken
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [21:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Writes land at once; indexes past the list are dropped in the datapath.
  assign cfg_ready = 1'b1;

  // Controller: accepts items, holds one pending result behind the output
  // register, and waits for the volume unit on a finishing echo.
  utvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: trigger sequencing, echo timing, volume math, result register.
  utvm_dp u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_valid                (cfg_valid),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_op                    (in_op),
    .in_echo_level            (in_echo_level),
    .cmd                      (cmd),
    .sts                      (sts),
    .out_trigger_level        (out_trigger_level),
    .out_busy_res             (out_busy_res),
    .out_done_res             (out_done_res),
    .out_timed_out            (out_timed_out),
    .out_volume_hundredth_gal (out_volume_hundredth_gal),
    .out_full_res             (out_full_res),
    .out_empty_res            (out_empty_res)
  );

endmodule

// ===== rtl/utvm_ctrl.sv =====
// Controller for the tank volume meter: handshakes, pending result, volume wait.
// Depends on utvm_pkg.
module utvm_ctrl
  import utvm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic CS_IDLE = 1'b0;
  localparam logic CS_CALC = 1'b1;

  logic st_r, st_nxt;
  logic pend_r, pend_nxt;
  logic ov_r, ov_nxt;
  logic load_out, accept;

  assign load_out  = pend_r && (!ov_r || out_ready);
  assign in_ready  = (st_r == CS_IDLE) && (!pend_r || load_out);
  assign accept    = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    st_nxt        = st_r;
    pend_nxt      = pend_r && !load_out;
    ov_nxt        = load_out || (ov_r && !out_ready);
    cmd.step      = accept;
    cmd.vol_start = 1'b0;
    cmd.load_out  = load_out;
    unique case (st_r)
      CS_IDLE: begin
        if (accept) begin
          if (sts.fin_ok) begin
            st_nxt        = CS_CALC;
            cmd.vol_start = 1'b1;
          end else begin
            pend_nxt = 1'b1;
          end
        end
      end
      CS_CALC: begin
        if (sts.vol_done) begin
          st_nxt   = CS_IDLE;
          pend_nxt = 1'b1;
        end
      end
      default: st_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CS_IDLE;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

// ===== rtl/utvm_vol.sv =====
// Iterative volume unit: scaled height, D^2*|H|, product with the gallon factor,
// quotient by 1e19 from a reciprocal estimate plus one correction, saturation.
// Uses utvm_pkg.
module utvm_vol
  import utvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [12:0]        dia,
  input  logic [12:0]        dep,
  input  logic [16:0]        pw,
  output logic               done,
  output logic signed [24:0] vol
);

  localparam logic [3:0] V_IDLE = 4'd0;
  localparam logic [3:0] V_SUB  = 4'd1;
  localparam logic [3:0] V_MUL  = 4'd2;
  localparam logic [3:0] V_PLO  = 4'd3;
  localparam logic [3:0] V_PHI  = 4'd4;
  localparam logic [3:0] V_EST  = 4'd5;
  localparam logic [3:0] V_RLO  = 4'd6;
  localparam logic [3:0] V_RHI  = 4'd7;
  localparam logic [3:0] V_COR  = 4'd8;
  localparam logic [3:0] V_FIN  = 4'd9;

  logic [3:0]  vst_r;
  logic        done_r;
  logic [26:0] a_r;
  logic [27:0] b_r;
  logic [25:0] d2_r;
  logic        neg_r;
  logic [27:0] ah_r;
  logic [53:0] m_r;
  logic [88:0] p_r;
  logic [25:0] qe_r;
  logic [47:0] t_r;
  logic [25:0] q_r;
  logic signed [24:0] vol_r;

  logic [28:0] h;
  logic [57:0] est;
  logic [48:0] tlo;
  logic [47:0] thi;
  logic [47:0] rdiff;
  logic        ge_one, ge_two;
  logic [25:0] qs;

  assign h    = {2'b00, a_r} - {1'b0, b_r};
  // top 32 bits of P times the reciprocal: low by at most two
  assign est  = {26'd0, p_r[88:57]} * {32'd0, RECIP};
  assign tlo  = {23'd0, qe_r} * {26'd0, FIVE_19[22:0]};
  assign thi  = {22'd0, qe_r} * {26'd0, FIVE_19[44:23]};
  // (P >> 19) - qe * 5^19 lies below 3 * 5^19, so 48 bits hold it exactly
  assign rdiff  = p_r[66:19] - t_r;
  assign ge_one = rdiff >= {3'd0, FIVE_19};
  assign ge_two = rdiff >= {2'd0, FIVE_19, 1'b0};
  assign done = done_r;
  assign vol  = vol_r;

  always_comb begin
    if (neg_r) begin
      qs = (q_r > NEG_SAT) ? NEG_SAT : q_r;
    end else begin
      qs = (q_r > POS_SAT) ? POS_SAT : q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vst_r  <= V_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (vst_r)
        V_IDLE: begin
          if (start) begin
            a_r   <= {14'd0, dep} * DEPTH_SCALE;
            b_r   <= {11'd0, pw} * ECHO_SCALE;
            d2_r  <= {13'd0, dia} * {13'd0, dia};
            vst_r <= V_SUB;
          end
        end
        V_SUB: begin
          neg_r <= h[28];
          ah_r  <= h[28] ? 28'(-h) : h[27:0];
          vst_r <= V_MUL;
        end
        V_MUL: begin
          m_r   <= {28'd0, d2_r} * {26'd0, ah_r};
          vst_r <= V_PLO;
        end
        V_PLO: begin
          p_r   <= {27'd0, {35'd0, m_r[26:0]} * {27'd0, CONV}};
          vst_r <= V_PHI;
        end
        V_PHI: begin
          p_r   <= p_r + {{35'd0, m_r[53:27]} * {27'd0, CONV}, 27'd0};
          vst_r <= V_EST;
        end
        V_EST: begin
          qe_r  <= est[57:32];
          vst_r <= V_RLO;
        end
        V_RLO: begin
          t_r   <= tlo[47:0];
          vst_r <= V_RHI;
        end
        V_RHI: begin
          t_r   <= t_r + {thi[24:0], 23'd0};
          vst_r <= V_COR;
        end
        V_COR: begin
          q_r   <= qe_r + {25'd0, ge_one} + {25'd0, ge_two};
          vst_r <= V_FIN;
        end
        V_FIN: begin
          vol_r  <= neg_r ? 25'(-qs) : qs[24:0];
          done_r <= 1'b1;
          vst_r  <= V_IDLE;
        end
        default: vst_r <= V_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/utvm_dp.sv =====
// Datapath: config registers, trigger/echo phase tracking, result registers.
// Depends on utvm_pkg and utvm_vol.
module utvm_dp
  import utvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  input  logic               in_op,
  input  logic               in_echo_level,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_trigger_level,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic               out_timed_out,
  output logic signed [24:0] out_volume_hundredth_gal,
  output logic               out_full_res,
  output logic               out_empty_res
);

  logic [12:0] dia_r, dep_r;
  logic [21:0] cap_r;
  logic [16:0] tmo_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [16:0] since_r, since_nxt;
  logic [16:0] pw_r, pw_nxt;
  logic        fail_r, fail_nxt;
  logic        trig_r, trig_nxt;
  logic        done_r, done_nxt;
  logic signed [24:0] lastv_r;
  logic        lastv_clr;

  logic [17:0] since_inc;
  logic        over, busy;
  logic        vol_done;
  logic signed [24:0] vol;

  utvm_vol u_vol (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.vol_start),
    .dia   (dia_r),
    .dep   (dep_r),
    .pw    (pw_r),
    .done  (vol_done),
    .vol   (vol)
  );

  assign since_inc    = {1'b0, since_r} + 18'd1;
  assign over         = since_inc > {1'b0, tmo_r};
  assign busy         = (phase_r >= PH_LOW) && (phase_r <= PH_ECHO);
  assign sts.fin_ok   = in_op && (phase_r == PH_ECHO) && !in_echo_level;
  assign sts.vol_done = vol_done;

  always_comb begin
    phase_nxt = phase_r;
    since_nxt = since_r;
    pw_nxt    = pw_r;
    fail_nxt  = fail_r;
    trig_nxt  = 1'b0;
    done_nxt  = 1'b0;
    lastv_clr = 1'b0;
    if (!in_op) begin
      if (!busy) begin
        phase_nxt = PH_LOW;
        since_nxt = '0;
        pw_nxt    = '0;
      end
    end else begin
      unique case (phase_r) inside
        PH_LOW: begin
          if (since_inc >= 18'(PULSE_LOW_US)) begin
            phase_nxt = PH_HIGH;
            since_nxt = '0;
          end else begin
            since_nxt = since_inc[16:0];
          end
        end
        PH_HIGH: begin
          trig_nxt = 1'b1;
          if (since_inc >= 18'(PULSE_HIGH_US)) begin
            phase_nxt = PH_WAIT;
            since_nxt = '0;
          end else begin
            since_nxt = since_inc[16:0];
          end
        end
        PH_WAIT, PH_ECHO: begin
          since_nxt = since_inc[17] ? CNT_MAX : since_inc[16:0];
          if (phase_r == PH_WAIT) begin
            if (in_echo_level) begin
              phase_nxt = PH_ECHO;
              pw_nxt    = 17'd1;
            end else if (over) begin
              fail_nxt  = 1'b1;
              lastv_clr = 1'b1;
              phase_nxt = PH_IDLE;
              since_nxt = '0;
              done_nxt  = 1'b1;
            end
          end else if (!in_echo_level) begin
            // good echo: volume comes from the volume unit
            fail_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
            since_nxt = '0;
            done_nxt  = 1'b1;
          end else begin
            if (pw_r != CNT_MAX) pw_nxt = pw_r + 17'd1;
            if (over) begin
              fail_nxt  = 1'b1;
              lastv_clr = 1'b1;
              phase_nxt = PH_IDLE;
              since_nxt = '0;
              done_nxt  = 1'b1;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dia_r   <= 13'd300;
      dep_r   <= 13'd500;
      cap_r   <= 22'd1000;
      tmo_r   <= 17'd100000;
      phase_r <= PH_IDLE;
      since_r <= '0;
      pw_r    <= '0;
      fail_r  <= 1'b0;
      lastv_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DIA:   dia_r <= cfg_data[12:0];
          CFG_DEPTH: dep_r <= cfg_data[12:0];
          CFG_CAP:   cap_r <= cfg_data;
          CFG_TMO:   tmo_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        phase_r <= phase_nxt;
        since_r <= since_nxt;
        pw_r    <= pw_nxt;
        fail_r  <= fail_nxt;
      end
      if (cmd.step && lastv_clr) lastv_r <= '0;
      else if (vol_done) lastv_r <= vol;
    end
  end

  // per-item flags, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      trig_r <= trig_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_trigger_level        <= trig_r;
      out_busy_res             <= busy;
      out_done_res             <= done_r;
      out_timed_out            <= fail_r;
      out_volume_hundredth_gal <= lastv_r;
      out_full_res             <= $signed({lastv_r[24], lastv_r}) >= $signed({4'd0, cap_r});
      out_empty_res            <= lastv_r[24] || (lastv_r == '0);
    end
  end

endmodule
